@@ design/tcse_pkg.sv @@
// ----------------------------------------------------------------------------
// tcse_pkg: shared types and constants of the text console scrollback engine
// Command word passed from the front end to the back end, character codes,
// colour defaults and interface widths.
// ----------------------------------------------------------------------------
package tcse_pkg;

  // default geometry
  localparam int DEF_STORE_LINES = 128;
  localparam int DEF_SCREEN_COLS = 80;
  localparam int DEF_SCREEN_ROWS = 25;

  // stream widths
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 40;

  // command queue depth between front and back
  localparam int CMD_FIFO_DEPTH = 2;

  // character codes
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_RETURN  = 8'd13;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] BLANK_CHAR = 8'h20;

  // colours
  localparam logic [7:0] DEFAULT_COLOUR = 8'h0F;
  localparam logic [3:0] DEFAULT_FG     = 4'hF;

  // tab stops
  localparam int TAB_STEP = 8;

  // operations after classification
  typedef enum logic [3:0] {
    OP_PUT     = 4'd0,
    OP_NEWLINE = 4'd1,
    OP_RETURN  = 4'd2,
    OP_TAB     = 4'd3,
    OP_COLOUR  = 4'd4,
    OP_CLEAR   = 4'd5,
    OP_UP      = 4'd6,
    OP_DOWN    = 4'd7,
    OP_READ    = 4'd8,
    OP_NOP     = 4'd9
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] char_code;
    logic [3:0] foreground;
    logic [3:0] background;
    logic [4:0] screen_row;
    logic [6:0] screen_col;
  } cmd_t;

endpackage

@@ design/tcse_front.sv @@
// ----------------------------------------------------------------------------
// tcse_front: input word acceptance and classification
// Unpacks the input word, decodes the function code and the control
// characters into one operation, and pushes the command into the queue.
// ----------------------------------------------------------------------------
module tcse_front
  import tcse_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [IN_TUSER_W-1:0] in_tuser,
  input  logic                  fifo_full,
  input  logic                  init_busy,
  output logic                  push,
  output cmd_t                  push_cmd
);

  // function codes on tuser
  localparam logic [2:0] FUNC_PUT    = 3'd0;
  localparam logic [2:0] FUNC_COLOUR = 3'd1;
  localparam logic [2:0] FUNC_CLEAR  = 3'd2;
  localparam logic [2:0] FUNC_UP     = 3'd3;
  localparam logic [2:0] FUNC_DOWN   = 3'd4;
  localparam logic [2:0] FUNC_READ   = 3'd5;

  logic in_seen_r;

  // accept while the queue has room and the store is initialized
  assign in_tready = !fifo_full && !init_busy && in_seen_r;
  assign push      = in_tvalid && in_tready;

  // settle register, set once reset is released, gates the first word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_seen_r <= 1'b0;
    end else begin
      in_seen_r <= 1'b1;
    end
  end

  // field unpacking and operation decode
  always_comb begin
    push_cmd.char_code  = in_tdata[7:0];
    push_cmd.foreground = in_tdata[11:8];
    push_cmd.background = in_tdata[15:12];
    push_cmd.screen_row = in_tdata[20:16];
    push_cmd.screen_col = in_tdata[27:21];
    unique case (in_tuser[2:0])
      FUNC_PUT: begin
        if (in_tdata[7:0] == CH_NEWLINE) begin
          push_cmd.op = OP_NEWLINE;
        end else if (in_tdata[7:0] == CH_RETURN) begin
          push_cmd.op = OP_RETURN;
        end else if (in_tdata[7:0] == CH_TAB) begin
          push_cmd.op = OP_TAB;
        end else begin
          push_cmd.op = OP_PUT;
        end
      end
      FUNC_COLOUR: push_cmd.op = OP_COLOUR;
      FUNC_CLEAR:  push_cmd.op = OP_CLEAR;
      FUNC_UP:     push_cmd.op = OP_UP;
      FUNC_DOWN:   push_cmd.op = OP_DOWN;
      FUNC_READ:   push_cmd.op = OP_READ;
      default:     push_cmd.op = OP_NOP;
    endcase
  end

endmodule

@@ design/tcse_cmd_fifo.sv @@
// ----------------------------------------------------------------------------
// tcse_cmd_fifo: command queue between front end and back end
// Small first-in first-out buffer of decoded commands, so that input
// acceptance and execution stall independently.
// ----------------------------------------------------------------------------
module tcse_cmd_fifo
  import tcse_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic valid,
  output cmd_t head
);

  localparam int DEPTH = CMD_FIFO_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  cmd_t            slot_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [PW:0]     count_r, count_nxt;

  assign full  = (count_r == (PW+1)'(DEPTH));
  assign valid = (count_r != '0);
  assign head  = slot_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + (PW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ design/tcse_back.sv @@
// ----------------------------------------------------------------------------
// tcse_back: command execution and cell store
// Holds the cell memory as a ring of rows, the cursor, view and colour,
// runs the clearing sweep and the row blanking on scroll, and drives the
// registered result word.
// ----------------------------------------------------------------------------
module tcse_back
  import tcse_pkg::*;
#(
  parameter int STORE_LINES = DEF_STORE_LINES,
  parameter int SCREEN_COLS = DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cmd_valid,
  input  cmd_t                   cmd,
  output logic                   cmd_pop,
  output logic                   init_busy,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int CELLS = STORE_LINES * SCREEN_COLS;
  localparam int AW    = $clog2(CELLS);
  localparam int LW    = $clog2(STORE_LINES);
  localparam int CW    = $clog2(SCREEN_COLS);
  localparam int SUMW  = $clog2(STORE_LINES + SCREEN_ROWS + 1);

  localparam logic [AW-1:0]   COLS_A  = AW'(SCREEN_COLS);
  localparam logic [AW-1:0]   LAST_A  = AW'(CELLS - 1);
  localparam logic [CW:0]     COLS_C  = (CW+1)'(SCREEN_COLS);
  localparam logic [CW-1:0]   LASTC_C = CW'(SCREEN_COLS - 1);
  localparam logic [LW:0]     STORE_C = (LW+1)'(STORE_LINES);
  localparam logic [SUMW-1:0] ROWS_S  = SUMW'(SCREEN_ROWS);
  localparam logic [SUMW-1:0] STORE_S = SUMW'(STORE_LINES);
  localparam logic [CW:0]     TAB_C   = (CW+1)'(TAB_STEP);
  localparam logic [CW:0]     TABM_C  = (CW+1)'(TAB_STEP - 1);

  typedef enum logic [4:0] {
    S_INIT  = 5'b00001,
    S_IDLE  = 5'b00010,
    S_CLEAR = 5'b00100,
    S_BLANK = 5'b01000,
    S_READ  = 5'b10000
  } state_t;

  state_t          state_r, state_nxt;
  logic [AW-1:0]   sweep_cnt_r, sweep_cnt_nxt;
  logic [CW-1:0]   col_cnt_r, col_cnt_nxt;
  logic [LW-1:0]   blank_row_r, blank_row_nxt;
  logic [LW-1:0]   base_r, base_nxt;
  logic [LW-1:0]   cursor_line_r, cursor_line_nxt;
  logic [CW-1:0]   cursor_col_r, cursor_col_nxt;
  logic [LW-1:0]   view_start_r, view_start_nxt;
  logic [7:0]      colour_r, colour_nxt;
  logic            rd_blank_r, rd_blank_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [15:0]     out_cell_r, out_cell_nxt;
  logic [6:0]      out_view_r, out_view_nxt;
  logic [6:0]      out_line_r, out_line_nxt;
  logic [6:0]      out_col_r, out_col_nxt;

  // cell memory
  logic [15:0]     cell_mem [CELLS];
  logic            mem_we;
  logic [AW-1:0]   mem_waddr;
  logic [15:0]     mem_wdata;
  logic [AW-1:0]   mem_raddr;
  logic [15:0]     mem_rdata_r;

  // put character path
  logic [LW-1:0]   put_line;
  logic [CW-1:0]   put_col;
  logic [LW-1:0]   put_view;
  logic            put_scroll;

  // logical row to physical row of the ring
  function automatic logic [LW-1:0] phys_row(input logic [LW-1:0] lr,
                                             input logic [LW-1:0] b);
    logic [LW:0] s;
    s = {1'b0, lr} + {1'b0, b};
    if (s >= STORE_C) begin
      s = s - STORE_C;
    end
    return s[LW-1:0];
  endfunction

  function automatic logic [AW-1:0] row_addr(input logic [LW-1:0] pr);
    return AW'(pr) * COLS_A;
  endfunction

  assign init_busy  = (state_r == S_INIT);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_col_r, out_line_r, out_view_r, out_cell_r};

  // cursor advance, wrap, scroll and view follow for a put, newline, return or tab
  always_comb begin
    logic [CW:0]     col_t;
    logic [LW:0]     line_t;
    logic [SUMW-1:0] line_s;
    col_t  = {1'b0, cursor_col_r};
    line_t = {1'b0, cursor_line_r};
    unique case (cmd.op)
      OP_NEWLINE: begin
        col_t  = '0;
        line_t = line_t + (LW+1)'(1);
      end
      OP_RETURN: col_t = '0;
      OP_TAB:    col_t = (col_t + TAB_C) & ~TABM_C;
      default:   col_t = col_t + (CW+1)'(1);
    endcase
    if (col_t >= COLS_C) begin
      col_t  = '0;
      line_t = line_t + (LW+1)'(1);
    end
    put_scroll = (line_t >= STORE_C);
    if (put_scroll) begin
      line_t = STORE_C - (LW+1)'(1);
    end
    line_s = SUMW'(line_t);
    if (line_s >= SUMW'(view_start_r) + ROWS_S) begin
      put_view = LW'(line_s + SUMW'(1) - ROWS_S);
    end else begin
      put_view = view_start_r;
    end
    put_line = line_t[LW-1:0];
    put_col  = col_t[CW-1:0];
  end

  // sequencer and command execution
  always_comb begin
    logic [SUMW-1:0] rline_s;
    logic            row_bad;
    logic            col_bad;
    state_nxt       = state_r;
    sweep_cnt_nxt   = sweep_cnt_r;
    col_cnt_nxt     = col_cnt_r;
    blank_row_nxt   = blank_row_r;
    base_nxt        = base_r;
    cursor_line_nxt = cursor_line_r;
    cursor_col_nxt  = cursor_col_r;
    view_start_nxt  = view_start_r;
    colour_nxt      = colour_r;
    rd_blank_nxt    = rd_blank_r;
    out_valid_nxt   = out_valid_r && !out_tready;
    out_cell_nxt    = out_cell_r;
    out_view_nxt    = out_view_r;
    out_line_nxt    = out_line_r;
    out_col_nxt     = out_col_r;
    mem_we          = 1'b0;
    mem_waddr       = '0;
    mem_wdata       = {colour_r, BLANK_CHAR};
    cmd_pop         = 1'b0;
    rline_s         = SUMW'(view_start_r) + SUMW'(cmd.screen_row);
    row_bad         = ({2'b00, cmd.screen_row} >= 7'(SCREEN_ROWS));
    col_bad         = ({1'b0, cmd.screen_col} >= 8'(SCREEN_COLS));
    mem_raddr       = row_addr(phys_row(rline_s[LW-1:0], base_r)) + AW'(cmd.screen_col);

    unique case (state_r)
      // blanking sweep over the whole store
      S_INIT, S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_cnt_r;
        if (sweep_cnt_r == LAST_A) begin
          state_nxt = S_IDLE;
        end else begin
          sweep_cnt_nxt = sweep_cnt_r + AW'(1);
        end
      end

      // blank the row that came in at the bottom
      S_BLANK: begin
        mem_we    = 1'b1;
        mem_waddr = row_addr(blank_row_r) + AW'(col_cnt_r);
        if (col_cnt_r == LASTC_C) begin
          state_nxt = S_IDLE;
        end else begin
          col_cnt_nxt = col_cnt_r + CW'(1);
        end
      end

      // read data is back from the memory
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_cell_nxt  = rd_blank_r ? {colour_r, BLANK_CHAR} : mem_rdata_r;
        out_view_nxt  = 7'(view_start_r);
        out_line_nxt  = 7'(cursor_line_r);
        out_col_nxt   = 7'(cursor_col_r);
        state_nxt     = S_IDLE;
      end

      S_IDLE: begin
        if (cmd_valid && (!out_valid_r || out_tready)) begin
          cmd_pop = 1'b1;
          unique case (cmd.op)
            OP_PUT, OP_NEWLINE, OP_RETURN, OP_TAB: begin
              if (cmd.op == OP_PUT) begin
                mem_we    = 1'b1;
                mem_waddr = row_addr(phys_row(cursor_line_r, base_r)) + AW'(cursor_col_r);
                mem_wdata = {colour_r, cmd.char_code};
              end
              cursor_line_nxt = put_line;
              cursor_col_nxt  = put_col;
              view_start_nxt  = put_view;
              if (put_scroll) begin
                blank_row_nxt = base_r;
                base_nxt      = (base_r == LW'(STORE_LINES - 1)) ? '0 : base_r + LW'(1);
                col_cnt_nxt   = '0;
                state_nxt     = S_BLANK;
              end
            end
            OP_COLOUR: colour_nxt = {cmd.background, cmd.foreground};
            OP_CLEAR: begin
              colour_nxt      = {cmd.background, DEFAULT_FG};
              cursor_line_nxt = '0;
              cursor_col_nxt  = '0;
              view_start_nxt  = '0;
              base_nxt        = '0;
              sweep_cnt_nxt   = '0;
              state_nxt       = S_CLEAR;
            end
            OP_UP: begin
              if (view_start_r != '0) begin
                view_start_nxt = view_start_r - LW'(1);
              end
            end
            OP_DOWN: begin
              if (SUMW'(view_start_r) + ROWS_S <= SUMW'(cursor_line_r)) begin
                view_start_nxt = view_start_r + LW'(1);
              end
            end
            OP_READ: begin
              rd_blank_nxt = row_bad || col_bad || (rline_s >= STORE_S);
              state_nxt    = S_READ;
            end
            default: begin
            end
          endcase
          // result word for everything but a read
          if (cmd.op != OP_READ) begin
            out_valid_nxt = 1'b1;
            out_cell_nxt  = '0;
            out_view_nxt  = 7'(view_start_nxt);
            out_line_nxt  = 7'(cursor_line_nxt);
            out_col_nxt   = 7'(cursor_col_nxt);
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_INIT;
      sweep_cnt_r   <= '0;
      base_r        <= '0;
      cursor_line_r <= '0;
      cursor_col_r  <= '0;
      view_start_r  <= '0;
      colour_r      <= DEFAULT_COLOUR;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      sweep_cnt_r   <= sweep_cnt_nxt;
      base_r        <= base_nxt;
      cursor_line_r <= cursor_line_nxt;
      cursor_col_r  <= cursor_col_nxt;
      view_start_r  <= view_start_nxt;
      colour_r      <= colour_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    col_cnt_r   <= col_cnt_nxt;
    blank_row_r <= blank_row_nxt;
    rd_blank_r  <= rd_blank_nxt;
    out_cell_r  <= out_cell_nxt;
    out_view_r  <= out_view_nxt;
    out_line_r  <= out_line_nxt;
    out_col_r   <= out_col_nxt;
  end

  // memory write port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cell_mem[mem_waddr] <= mem_wdata;
    end
  end

  // memory read port
  always_ff @(posedge clk) begin
    mem_rdata_r <= cell_mem[mem_raddr];
  end

endmodule

@@ design/text_console_scrollback_engine_core.sv @@
// ----------------------------------------------------------------------------
// text_console_scrollback_engine_core: text console with scrollback store
// Front end, command queue and back end of the console engine.
// ----------------------------------------------------------------------------
// After reset the engine blanks its cell store to white-on-black spaces, one
// cell per cycle; in_tready stays low until it is done. Each word then gives
// exactly one result word. Words are decoded on entry and wait in a two-entry
// command queue; the execution side takes one command per cycle for put,
// colour and view operations while the result words are taken, and a cell
// read passes through the registered read port of the cell memory and a read
// state before its result. A put that runs past the last stored row shifts
// the ring of rows by one and blanks the new row; a clear blanks the whole
// store. The result of these comes out at once; the next command waits until
// the store write sweep is over.
module text_console_scrollback_engine_core
  import tcse_pkg::*;
#(
  parameter int STORE_LINES = DEF_STORE_LINES,
  parameter int SCREEN_COLS = DEF_SCREEN_COLS,
  parameter int SCREEN_ROWS = DEF_SCREEN_ROWS
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // char_code[7:0], foreground[11:8], background[15:12],
  // screen_row[20:16], screen_col[27:21], zero[31:28]
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // func[2:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // cell_entry[15:0], view_line[22:16], write_line_out[29:23],
  // cursor_col[36:30], zero[39:37]
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic fifo_full;
  logic fifo_valid;
  logic push;
  logic pop;
  logic init_busy;
  cmd_t push_cmd;
  cmd_t head_cmd;

  // accept and classify
  tcse_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .fifo_full (fifo_full),
    .init_busy (init_busy),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // command queue
  tcse_cmd_fifo u_cmd_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (fifo_full),
    .pop      (pop),
    .valid    (fifo_valid),
    .head     (head_cmd)
  );

  // execution and store
  tcse_back #(
    .STORE_LINES (STORE_LINES),
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (fifo_valid),
    .cmd        (head_cmd),
    .cmd_pop    (pop),
    .init_busy  (init_busy),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ design/tcse_checker.sv @@
// ----------------------------------------------------------------------------
// tcse_checker: port-level checks of the console engine
// Reset behavior, result word hold under stall and cursor/view sanity of
// the result words, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tcse_checker
  import tcse_pkg::*;
#(
  parameter int STORE_LINES = DEF_STORE_LINES,
  parameter int SCREEN_COLS = DEF_SCREEN_COLS
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // no word accepted right after a reset
  a_no_accept_after_reset: assert property (@(posedge clk)
    !rst_n |=> !in_tready)
    else $error("input accepted right after reset");

  // no result right after reset
  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result word right after reset");

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed under stall");

  // cursor column stays inside the row
  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[36:30] < 7'(SCREEN_COLS)))
    else $error("cursor column past row end");

  // view never starts below the write line (checked for stores of up to 128 lines)
  a_view_le_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (STORE_LINES <= 128) |-> (out_tdata[22:16] <= out_tdata[29:23]))
    else $error("view starts below write line");

endmodule

bind text_console_scrollback_engine_core tcse_checker #(
  .STORE_LINES (STORE_LINES),
  .SCREEN_COLS (SCREEN_COLS)
) u_tcse_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
